/* design/assert_macros.svh */
// assertion macros shared by the checker files
// each macro expects a clock named clk in scope, and all but AST_NEXT_ANY a reset named rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while reset is high
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define AST_NEXT_ANY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/fdt_pkg.sv */
// shared types, constants and digit helpers for the frequency text formatter
// no dependencies
`default_nettype none

package fdt_pkg;

  localparam int unsigned FreqWidth = 20;
  localparam int unsigned KhzWidth  = 10;

  localparam logic [FreqWidth-1:0] FreqSatMax = 20'd999999;
  // ceil(2^30 / 1000): f * KiloRecip >> 30 gives f / 1000 for f up to 999999
  localparam logic [20:0] KiloRecip = 21'd1073742;
  localparam int unsigned KiloShift = 30;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChK     = 8'h4B;

  typedef logic [FreqWidth-1:0] freq_t;
  typedef logic [KhzWidth-1:0]  part_t;
  typedef logic [7:0]           glyph_t;
  typedef glyph_t [0:7]         text_t;

  // value split at the thousands boundary
  typedef struct packed {
    part_t khz;
    part_t low;
  } split_t;

  // three decimal digits of a value below 1000
  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] unit;
  } dec3_t;

  // reciprocal multiplies: v*41 >> 12 is v/100 below 1000, r*205 >> 11 is r/10 below 100
  function automatic dec3_t to_dec3(input part_t v);
    logic [15:0] hprod;
    logic [6:0]  rem;
    logic [14:0] tprod;
    dec3_t       d;
    hprod  = 16'(v) * 16'd41;
    d.hund = hprod[15:12];
    rem    = 7'(v - 10'(d.hund) * 10'd100);
    tprod  = 15'(rem) * 15'd205;
    d.tens = tprod[14:11];
    d.unit = 4'(rem - 7'(d.tens) * 7'd10);
    return d;
  endfunction

  function automatic glyph_t digit_char(input logic [3:0] d);
    return ChZero + 8'(d);
  endfunction

endpackage

`default_nettype wire

/* design/fdt_chan_if.sv */
// valid/ready channel interfaces for the frequency word and the text word
// depends on fdt_pkg
`default_nettype none

interface freq_chan_if;
  import fdt_pkg::*;
  logic  valid;
  logic  ready;
  freq_t freq_hz;
  modport source (output valid, output freq_hz, input ready);
  modport sink (input valid, input freq_hz, output ready);
endinterface

interface text_chan_if;
  import fdt_pkg::*;
  logic   valid;
  logic   ready;
  glyph_t glyph_0;
  glyph_t glyph_1;
  glyph_t glyph_2;
  glyph_t glyph_3;
  glyph_t glyph_4;
  glyph_t glyph_5;
  glyph_t glyph_6;
  glyph_t glyph_7;
  modport source (output valid, output glyph_0, output glyph_1, output glyph_2,
                  output glyph_3, output glyph_4, output glyph_5, output glyph_6,
                  output glyph_7, input ready);
  modport sink (input valid, input glyph_0, input glyph_1, input glyph_2,
                input glyph_3, input glyph_4, input glyph_5, input glyph_6,
                input glyph_7, output ready);
endinterface

`default_nettype wire

/* design/fdt_split.sv */
// splits a saturated frequency into kilohertz and remainder below 1000
// depends on fdt_pkg
`default_nettype none

module fdt_split (
  input  fdt_pkg::freq_t  freq,
  output fdt_pkg::split_t parts
);
  import fdt_pkg::*;

  logic [40:0] prod;
  logic [19:0] kprod;
  part_t       khz;

  // divide by 1000 through a reciprocal multiply
  assign prod = 41'(freq) * 41'(KiloRecip);
  assign khz  = prod[KiloShift+KhzWidth-1:KiloShift];

  // remainder fits in ten bits, so the low bits of the subtraction suffice
  assign kprod      = 20'(khz) * 20'd1000;
  assign parts.khz  = khz;
  assign parts.low  = freq[KhzWidth-1:0] - kprod[KhzWidth-1:0];

endmodule

`default_nettype wire

/* design/fdt_format.sv */
// turns the split value into eight display characters with leading blanking
// depends on fdt_pkg
`default_nettype none

module fdt_format (
  input  fdt_pkg::split_t parts,
  output fdt_pkg::text_t  text
);
  import fdt_pkg::*;

  dec3_t hi;
  dec3_t lo;
  logic  is_khz;

  assign hi     = to_dec3(parts.khz);
  assign lo     = to_dec3(parts.low);
  assign is_khz = (parts.khz != '0);

  // kilohertz form "DDD.DDDK" or hertz form of five spaces and three digits, leading zeros blanked in both
  always_comb begin
    if (is_khz) begin
      text[0] = (hi.hund != '0) ? digit_char(hi.hund) : ChSpace;
      text[1] = (hi.hund != '0 || hi.tens != '0) ? digit_char(hi.tens) : ChSpace;
      text[2] = digit_char(hi.unit);
      text[3] = ChPoint;
      text[4] = digit_char(lo.hund);
      text[5] = digit_char(lo.tens);
      text[6] = digit_char(lo.unit);
      text[7] = ChK;
    end else begin
      text[0] = ChSpace;
      text[1] = ChSpace;
      text[2] = ChSpace;
      text[3] = ChSpace;
      text[4] = ChSpace;
      text[5] = (lo.hund != '0) ? digit_char(lo.hund) : ChSpace;
      text[6] = (lo.hund != '0 || lo.tens != '0) ? digit_char(lo.tens) : ChSpace;
      text[7] = digit_char(lo.unit);
    end
  end

endmodule

`default_nettype wire

/* design/frequency_decimal_text_formatter.sv */
// top level of the frequency text formatter: three-stage valid/ready pipeline
// depends on fdt_pkg, fdt_chan_if, fdt_split, fdt_format
//
// usage
//   in_freq carries one frequency word in hertz; values above 999999 are
//   clamped to 999999. out_text carries eight ASCII characters, glyph_0 at
//   the left: below 1 kHz five spaces and three digits with leading zeros
//   blanked, otherwise "DDD.DDDK" with the two leading zeros blanked.
//   each word passes an input register, a register after the divide by
//   1000, and the result register.
//   throughput is one word per cycle while the receiver holds ready; each stage
//   holds one word and moves on when the stage after it is empty or draining,
//   so the rate is set by the single result register and the receiver's ready.
//   when the receiver stalls the result holds and up to two more words are
//   still taken into the earlier stages before in_freq.ready drops.
//   reset clears all stage valid bits; no word is in flight afterwards.
`default_nettype none

module frequency_decimal_text_formatter (
  input  wire          clk,
  input  wire          rst,
  freq_chan_if.sink    in_freq,
  text_chan_if.source  out_text
);
  import fdt_pkg::*;

  logic   v0, v1, v2;
  logic   rdy0, rdy1, rdy2;
  freq_t  freq0;
  freq_t  freq_sat;
  split_t split_next;
  split_t split1;
  text_t  text_next;
  text_t  text2;

  // per-stage advance
  assign rdy2          = !v2 || out_text.ready;
  assign rdy1          = !v1 || rdy2;
  assign rdy0          = !v0 || rdy1;
  assign in_freq.ready = rdy0;

  // clamp on the way into the input register
  assign freq_sat = (in_freq.freq_hz > FreqSatMax) ? FreqSatMax : in_freq.freq_hz;

  fdt_split u_split (
    .freq  (freq0),
    .parts (split_next)
  );

  fdt_format u_format (
    .parts (split1),
    .text  (text_next)
  );

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_freq.valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (rdy0 && in_freq.valid) freq0  <= freq_sat;
    if (rdy1 && v0)            split1 <= split_next;
    if (rdy2 && v1)            text2  <= text_next;
  end

  // result word
  assign out_text.valid   = v2;
  assign out_text.glyph_0 = text2[0];
  assign out_text.glyph_1 = text2[1];
  assign out_text.glyph_2 = text2[2];
  assign out_text.glyph_3 = text2[3];
  assign out_text.glyph_4 = text2[4];
  assign out_text.glyph_5 = text2[5];
  assign out_text.glyph_6 = text2[6];
  assign out_text.glyph_7 = text2[7];

endmodule

`default_nettype wire

/* design/fdt_checker.sv */
// port-level checks for the frequency text formatter, bound to the top level
// depends on fdt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module fdt_checker (
  input wire             clk,
  input wire             rst,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input fdt_pkg::glyph_t g2,
  input fdt_pkg::glyph_t g3,
  input fdt_pkg::glyph_t g7
);
  import fdt_pkg::*;

  logic out_stall;
  logic g2_digit;
  logic g7_digit;

  // shorthand for the checks below
  assign out_stall = out_valid && !out_ready;
  assign g2_digit  = (g2 >= ChZero) && (g2 <= ChZero + 8'd9);
  assign g7_digit  = (g7 >= ChZero) && (g7 <= ChZero + 8'd9);

  // a stalled word stays valid, with glyph_3 and glyph_7 unchanged
  `AST_NEXT(a_out_hold, out_stall, out_valid && $stable(g7) && $stable(g3), "stalled word changed")

  // nothing comes out in the cycle after reset
  `AST_NEXT_ANY(a_reset_empty, rst, !out_valid, "word after reset")

  // kilohertz form always has the point and a digit before it
  `AST_IMPL(a_khz_form, out_valid && g7 == ChK, g3 == ChPoint && g2_digit, "bad kilohertz text")

  // hertz form ends in a digit with a blank fourth place
  `AST_IMPL(a_hz_form, out_valid && g7 != ChK, g7_digit && g3 == ChSpace, "bad hertz text")

  // an empty or draining result register never blocks the input
  `AST_IMPL(a_drain_ready, in_valid && (!out_valid || out_ready), in_ready, "input blocked")

endmodule

bind frequency_decimal_text_formatter fdt_checker u_fdt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_freq.valid),
  .in_ready  (in_freq.ready),
  .out_valid (out_text.valid),
  .out_ready (out_text.ready),
  .g2        (out_text.glyph_2),
  .g3        (out_text.glyph_3),
  .g7        (out_text.glyph_7)
);

`default_nettype wire

/* dv/tb_top.sv */
// testbench for the frequency text formatter: drives hertz words, checks eight-character text words
// depends on fdt_pkg, fdt_chan_if and frequency_decimal_text_formatter
`timescale 1ns / 1ps

module tb_top;
  import fdt_pkg::*;

  localparam int unsigned RandWords  = 2000;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 12;

  // expected text words and their comparison against the block's output
  class text_scoreboard;
    text_t       text_q[$];
    int unsigned fail_count;
    int unsigned report_count;

    // hertz value to display text, with saturation and leading-zero blanking
    function text_t format_freq(input freq_t raw);
      int unsigned f;
      int unsigned v;
      int unsigned dig [0:5];
      int          i;
      text_t       t;
      f = (raw > FreqSatMax) ? int'(FreqSatMax) : int'(raw);
      v = f;
      for (i = 0; i < 6; i++) begin
        dig[i] = v % 10;
        v      = v / 10;
      end
      if (f < 1000) begin
        for (i = 0; i < 5; i++) t[i] = ChSpace;
        t[5] = (dig[2] == 0) ? ChSpace : ChZero + 8'(dig[2]);
        t[6] = (dig[2] == 0 && dig[1] == 0) ? ChSpace : ChZero + 8'(dig[1]);
        t[7] = ChZero + 8'(dig[0]);
      end else begin
        t[0] = (dig[5] == 0) ? ChSpace : ChZero + 8'(dig[5]);
        t[1] = (dig[5] == 0 && dig[4] == 0) ? ChSpace : ChZero + 8'(dig[4]);
        t[2] = ChZero + 8'(dig[3]);
        t[3] = ChPoint;
        t[4] = ChZero + 8'(dig[2]);
        t[5] = ChZero + 8'(dig[1]);
        t[6] = ChZero + 8'(dig[0]);
        t[7] = ChK;
      end
      return t;
    endfunction

    function void note_freq(input freq_t f);
      text_q.push_back(format_freq(f));
    endfunction

    function void flag(input string what);
      fail_count++;
      if (report_count < 10) begin
        report_count++;
        $display("[%0t] %s", $realtime, what);
      end
    endfunction

    function void check_text(input text_t got);
      text_t want;
      int    i;
      if (text_q.size() == 0) begin
        flag($sformatf("text word with nothing pending: \"%s\"", got));
        return;
      end
      want = text_q.pop_front();
      for (i = 0; i < 8; i++) begin
        if (got[i] !== want[i])
          flag($sformatf("glyph_%0d: expected 8'h%02h actual 8'h%02h (\"%s\" vs \"%s\")",
                         i, want[i], got[i], want, got));
      end
    endfunction

    function int unsigned pending();
      return text_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  int unsigned cycle_cnt = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_stall_left = 0;
  text_scoreboard sb;

  freq_chan_if in_if ();
  text_chan_if out_if ();

  frequency_decimal_text_formatter u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_freq  (in_if),
    .out_text (out_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // hertz value drawn across the interesting ranges
  function automatic freq_t pick_freq();
    int unsigned r;
    r = $urandom_range(0, 11);
    case (r)
      0, 1:    return freq_t'($urandom_range(0, 999));
      2:       return freq_t'($urandom_range(0, 99));
      3, 4, 5: return freq_t'($urandom_range(1000, 999999));
      6:       return freq_t'($urandom_range(1000, 99999));
      7:       return freq_t'($urandom_range(1000000, 1048575));
      8: begin
        // near a formatting boundary
        case ($urandom_range(0, 3))
          0:       return freq_t'($urandom_range(990, 1010));
          1:       return freq_t'($urandom_range(9990, 10010));
          2:       return freq_t'($urandom_range(99990, 100010));
          default: return freq_t'($urandom_range(999990, 1000010));
        endcase
      end
      default: return freq_t'($urandom);
    endcase
  endfunction

  // one word on in_freq, optional idle cycles first
  task automatic send_word(input freq_t f);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.freq_hz <= f;
    do @(posedge clk); while (!in_if.ready);
    sb.note_freq(f);
  endtask

  // receiver: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready)
      sb.check_text({out_if.glyph_0, out_if.glyph_1, out_if.glyph_2, out_if.glyph_3,
                     out_if.glyph_4, out_if.glyph_5, out_if.glyph_6, out_if.glyph_7});
    if (rst) begin
      out_if.ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_if.ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      rx_stall_left <= pick_gap() - 1;
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("frequency_decimal_text_formatter: mismatch");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    freq_t       directed [$];
    int unsigned n;
    sb            = new();
    tx_idle_pct   = 30;
    rx_stall_pct  = 20;
    rst           <= 1'b1;
    in_if.valid   <= 1'b0;
    in_if.freq_hz <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, blanking edges, inner zeros, range limits, saturation
    directed = '{20'd0, 20'd1, 20'd9, 20'd10, 20'd50, 20'd99, 20'd100, 20'd105,
                 20'd500, 20'd999, 20'd1000, 20'd1001, 20'd9999, 20'd10000,
                 20'd10500, 20'd99999, 20'd100000, 20'd100005, 20'd123456,
                 20'd999999, 20'd1000000, 20'hFFFFF, 20'h55555, 20'hAAAAA};
    foreach (directed[i]) send_word(directed[i]);

    // random words; phases vary idling on both sides
    for (n = 0; n < RandWords; n++) begin
      if (n % 250 == 0) begin
        case ((n / 250) % 4)
          0: begin tx_idle_pct = 30; rx_stall_pct = 20; end
          1: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
          2: begin tx_idle_pct = 60; rx_stall_pct = 5;  end
          default: begin tx_idle_pct = 5; rx_stall_pct = 50; end
        endcase
      end
      send_word(pick_freq());
    end
    in_if.valid <= 1'b0;

    // drain and settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("frequency_decimal_text_formatter: match");
    end else begin
      $display("frequency_decimal_text_formatter: mismatch");
    end
    $finish;
  end

endmodule
